// ----- src/vsfa_pkg.sv -----
// Shared types and constants for the video sector frame assembler.
// No dependencies; imported by every module of the block.
`default_nettype none

package vsfa_pkg;

    localparam int SECTORS_PER_FRAME_MAX = 16;
    localparam int WORDS_PER_SECTOR      = 504;
    localparam int IDX_W                 = $clog2(SECTORS_PER_FRAME_MAX);

    localparam logic [15:0] MAGIC_OK   = 16'h0160;
    localparam logic [15:0] TYPE_VIDEO = 16'h8001;
    localparam logic [10:0] ROUND_ADD  = 11'd15;
    localparam logic [10:0] ROUND_MASK = 11'h7F0;
    localparam logic [8:0]  SL_FLOOR   = 9'h100;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        ST_APPENDED  = 3'd0,
        ST_IGNORED   = 3'd1,
        ST_BAD_MAGIC = 3'd2,
        ST_OLDER     = 3'd3,
        ST_IDX_RANGE = 3'd4,
        ST_TAKEN     = 3'd5,
        ST_NONE      = 3'd6,
        ST_ENDED     = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        RDY_NONE  = 3'b001,
        RDY_READY = 3'b010,
        RDY_ENDED = 3'b100
    } t_rdy;

    typedef struct packed {
        logic        req_type;
        logic [15:0] magic;
        logic [15:0] sector_type;
        logic [15:0] sector_index;
        logic [7:0]  sector_total;
        logic [15:0] frame_number;
        logic [9:0]  raw_width;
        logic [9:0]  raw_height;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic        buffer_select;
        logic [12:0] write_offset;
        logic        frame_started;
        logic [10:0] pic_width;
        logic [10:0] pic_height;
        logic [15:0] dropped_count;
        logic [16:0] frames_seen;
    } t_out_item;

    // Classified item as it sits in the queue between front and back.
    typedef struct packed {
        logic        is_take;
        logic        magic_ok;
        logic        type_ok;
        logic        idx_ok;
        logic [7:0]  total;
        logic [15:0] fnum;
        logic [10:0] width_r;
        logic [10:0] height_r;
        logic [12:0] offset;
    } t_cls;

endpackage

`default_nettype wire

// ----- src/vsfa_front.sv -----
// Front end: classifies a header or take request into a queue entry.
// Depends on vsfa_pkg.
`default_nettype none

module vsfa_front (
    input  wire vsfa_pkg::t_in_item i_item,
    output vsfa_pkg::t_cls          o_cls
);
    import vsfa_pkg::*;

    always_comb begin
        o_cls.is_take  = i_item.req_type;
        o_cls.magic_ok = (i_item.magic == MAGIC_OK);
        o_cls.type_ok  = (i_item.sector_type == TYPE_VIDEO);
        o_cls.idx_ok   = (i_item.sector_index < 16'(SECTORS_PER_FRAME_MAX));
        o_cls.total    = i_item.sector_total;
        o_cls.fnum     = i_item.frame_number;
        // round up to a multiple of 16
        o_cls.width_r  = ({1'b0, i_item.raw_width} + ROUND_ADD) & ROUND_MASK;
        o_cls.height_r = ({1'b0, i_item.raw_height} + ROUND_ADD) & ROUND_MASK;
        o_cls.offset   = 13'(WORDS_PER_SECTOR)
                       * {{(13 - IDX_W){1'b0}}, i_item.sector_index[IDX_W-1:0]};
    end

endmodule

`default_nettype wire

// ----- src/vsfa_queue.sv -----
// Short queue of classified items between front and back.
// Depends on vsfa_pkg.
`default_nettype none

module vsfa_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  wire vsfa_pkg::t_cls   i_data,
    input  wire                   i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output vsfa_pkg::t_cls        o_data
);
    import vsfa_pkg::*;

    t_cls              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

// ----- src/vsfa_back.sv -----
// Back end: frame state, double-buffer bookkeeping and the output register.
// Depends on vsfa_pkg.
`default_nettype none

module vsfa_back (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_entry_valid,
    input  wire vsfa_pkg::t_cls    i_entry,
    output logic                   o_pop,
    output logic                   o_out_valid,
    output vsfa_pkg::t_out_item    o_out_data,
    input  wire                    i_out_stall
);
    import vsfa_pkg::*;

    logic        r_have, n_have;
    logic [15:0] r_cur, n_cur;
    logic [8:0]  r_sl, n_sl;
    logic [15:0] r_dropped, n_dropped;
    logic        r_fill, n_fill;
    t_rdy        r_rdy, n_rdy;
    logic [10:0] r_bw [2];
    logic [10:0] r_bh [2];
    logic [10:0] n_bw [2];
    logic [10:0] n_bh [2];
    logic        r_out_valid;
    t_out_item   r_out, n_out;

    logic        newer;
    logic        older;
    logic        sel;
    logic [8:0]  sl_base;

    // output register frees up when empty or being taken this cycle
    assign o_pop       = i_entry_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign newer = !r_have || (i_entry.fnum > r_cur);
    assign older = r_have && (i_entry.fnum < r_cur);

    always_comb begin
        n_have    = r_have;
        n_cur     = r_cur;
        n_sl      = r_sl;
        n_dropped = r_dropped;
        n_fill    = r_fill;
        n_rdy     = r_rdy;
        n_bw      = r_bw;
        n_bh      = r_bh;
        sel       = r_fill;
        sl_base   = r_sl;

        n_out               = '0;
        n_out.status        = ST_IGNORED;

        if (i_entry.is_take) begin
            case (r_rdy)
                RDY_NONE: begin
                    n_out.status = ST_NONE;
                end
                RDY_READY: begin
                    n_out.status = ST_TAKEN;
                    n_rdy        = RDY_NONE;
                    sel          = !r_fill;
                end
                default: begin
                    n_out.status = ST_ENDED;
                end
            endcase
        end else if (!i_entry.magic_ok) begin
            n_rdy        = RDY_ENDED;
            n_out.status = ST_BAD_MAGIC;
        end else if (!i_entry.type_ok) begin
            n_out.status = ST_IGNORED;
        end else if (older) begin
            n_rdy        = RDY_ENDED;
            n_out.status = ST_OLDER;
        end else begin
            if (newer) begin
                // missed sectors leave the count nonzero
                if (r_sl != '0) begin
                    if (r_dropped != 16'hFFFF) begin
                        n_dropped = r_dropped + 16'd1;
                    end
                end else begin
                    n_rdy = RDY_READY;
                end
                n_have       = 1'b1;
                n_cur        = i_entry.fnum;
                sl_base      = {1'b0, i_entry.total};
                n_fill       = !r_fill;
                sel          = !r_fill;
                n_bw[sel]    = i_entry.width_r;
                n_bh[sel]    = i_entry.height_r;
                n_out.frame_started = 1'b1;
            end
            n_sl = (sl_base != SL_FLOOR) ? sl_base - 9'd1 : sl_base;
            if (i_entry.idx_ok) begin
                n_out.status       = ST_APPENDED;
                n_out.write_offset = i_entry.offset;
            end else begin
                n_out.status = ST_IDX_RANGE;
            end
        end

        n_out.buffer_select = sel;
        n_out.pic_width     = n_bw[sel];
        n_out.pic_height    = n_bh[sel];
        n_out.dropped_count = n_dropped;
        n_out.frames_seen   = n_have ? ({1'b0, n_cur} + 17'd1) : 17'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_cur       <= '0;
            r_sl        <= '0;
            r_dropped   <= '0;
            r_fill      <= 1'b0;
            r_rdy       <= RDY_NONE;
            r_bw[0]     <= '0;
            r_bw[1]     <= '0;
            r_bh[0]     <= '0;
            r_bh[1]     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_have    <= n_have;
                r_cur     <= n_cur;
                r_sl      <= n_sl;
                r_dropped <= n_dropped;
                r_fill    <= n_fill;
                r_rdy     <= n_rdy;
                r_bw      <= n_bw;
                r_bh      <= n_bh;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    a_drop_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_dropped >= $past(r_dropped))
        else $error("dropped frame count went backwards");

    a_start_flips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && n_out.frame_started) |=> r_fill != $past(r_fill))
        else $error("new frame without buffer flip");

    a_take_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_entry.is_take && r_rdy == RDY_READY) |=> r_rdy == RDY_NONE)
        else $error("taken frame still marked ready");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !o_pop)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// ----- src/video_sector_frame_assembler.sv -----
// Path: an accepted beat is classified, queued, then popped into the output register when free.
// Throughput: one beat per cycle while the output is not stalled; the two-entry queue
// and output register let input and output stall independently.
// Reset: synchronous, active low; no frame, nothing ready, counts cleared.
// Depends on vsfa_pkg, vsfa_front, vsfa_queue and vsfa_back.
`default_nettype none

module video_sector_frame_assembler (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire vsfa_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output vsfa_pkg::t_out_item      o_out_data
);
    import vsfa_pkg::*;

    t_cls cls;
    t_cls q_data;
    logic q_full;
    logic q_empty;
    logic pop;
    logic push;

    assign o_in_stall = q_full;
    assign push       = i_in_valid && !q_full;

    vsfa_front u_front (
        .i_item (i_in_data),
        .o_cls  (cls)
    );

    vsfa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    vsfa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_valid (!q_empty),
        .i_entry       (q_data),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data),
        .i_out_stall   (i_out_stall)
    );

endmodule

`default_nettype wire

// ----- verif/video_sector_frame_assembler_tb.sv -----
// Self-checking testbench for video_sector_frame_assembler: headers and takes go in,
// and a scoreboard predicts and compares every result beat. Directed cases come first.
// Depends on vsfa_pkg and the assembler RTL only.

module video_sector_frame_assembler_tb;
    import vsfa_pkg::*;

    localparam int IN_W      = $bits(t_in_item);
    localparam int ITEMS     = 1700;
    localparam int FRAME_CAP = 65000;

    // Predicts one result per beat and keeps the results still owed by the block.
    class frame_result_board;
        t_out_item   owed[$];
        int          mismatches;
        int          open_frame;
        int          highest;
        logic [8:0]  left;
        logic [15:0] dropped;
        logic        fill_buf;
        t_rdy        rdy;
        logic [10:0] width_of[2];
        logic [10:0] height_of[2];

        function new();
            mismatches = 0;
            open_frame = -1;
            highest    = -1;
            left       = '0;
            dropped    = '0;
            fill_buf   = 1'b0;
            rdy        = RDY_NONE;
            width_of   = '{default: '0};
            height_of  = '{default: '0};
        endfunction

        function logic [10:0] round_up16(logic [9:0] v);
            return (11'(v) + ROUND_ADD) & ROUND_MASK;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void note_beat(t_in_item it);
            t_out_item r;
            int        fnum;
            r = '0;
            r.status = ST_APPENDED;
            r.buffer_select = fill_buf;
            fnum = it.frame_number;
            if (it.req_type) begin
                case (rdy)
                    RDY_NONE:  r.status = ST_NONE;
                    RDY_READY: begin
                        r.status = ST_TAKEN;
                        r.buffer_select = ~fill_buf;
                        rdy = RDY_NONE;
                    end
                    default:   r.status = ST_ENDED;
                endcase
            end else if (it.magic != MAGIC_OK) begin
                rdy = RDY_ENDED;
                r.status = ST_BAD_MAGIC;
            end else if (it.sector_type != TYPE_VIDEO) begin
                r.status = ST_IGNORED;
            end else if (fnum < open_frame) begin
                rdy = RDY_ENDED;
                r.status = ST_OLDER;
            end else begin
                if (fnum > open_frame) begin
                    // previous frame: complete goes ready, short or overfull counts as dropped
                    if (left != '0) begin
                        if (dropped != 16'hFFFF) dropped = dropped + 16'd1;
                    end else begin
                        rdy = RDY_READY;
                    end
                    open_frame = fnum;
                    left = {1'b0, it.sector_total};
                    fill_buf = ~fill_buf;
                    r.buffer_select = fill_buf;
                    if (fnum > highest) highest = fnum;
                    width_of[fill_buf]  = round_up16(it.raw_width);
                    height_of[fill_buf] = round_up16(it.raw_height);
                    r.frame_started = 1'b1;
                end
                // counts down past zero, sticks at the floor
                if (left != SL_FLOOR) left = left - 9'd1;
                if (it.sector_index >= SECTORS_PER_FRAME_MAX) begin
                    r.status = ST_IDX_RANGE;
                end else begin
                    r.write_offset = 13'(WORDS_PER_SECTOR * it.sector_index);
                end
            end
            r.pic_width     = width_of[r.buffer_select];
            r.pic_height    = height_of[r.buffer_select];
            r.dropped_count = dropped;
            r.frames_seen   = 17'(highest + 1);
            owed.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_beat(t_out_item got);
            t_out_item want;
            if (owed.size() == 0) begin
                $error("result beat with nothing owed: status %0d", got.status);
                mismatches++;
                return;
            end
            want = owed.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("buffer_select", want.buffer_select, got.buffer_select);
            compare_field("write_offset", want.write_offset, got.write_offset);
            compare_field("frame_started", want.frame_started, got.frame_started);
            compare_field("pic_width", want.pic_width, got.pic_width);
            compare_field("pic_height", want.pic_height, got.pic_height);
            compare_field("dropped_count", want.dropped_count, got.dropped_count);
            compare_field("frames_seen", want.frames_seen, got.frames_seen);
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    frame_result_board board;
    int        sent = 0;
    int        burst_left = 0;
    int        next_frame = 0;
    int        stall_span = 0;
    int        stall_mode = 0;

    video_sector_frame_assembler DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Receiver: checks accepted beats, stalls in random modes, each held for a random span.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) board.check_beat(out_data);
        if (stall_span == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(16, 96);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= stall_span[3];
        endcase
    end

    function automatic t_in_item sector_item(int fnum, logic [15:0] idx, int total,
                                             logic [9:0] w, logic [9:0] h);
        t_in_item it;
        it = '0;
        it.magic        = MAGIC_OK;
        it.sector_type  = TYPE_VIDEO;
        it.sector_index = idx;
        it.sector_total = 8'(total);
        it.frame_number = 16'(fnum);
        it.raw_width    = w;
        it.raw_height   = h;
        return it;
    endfunction

    function automatic t_in_item random_item();
        return t_in_item'(IN_W'({$urandom, $urandom, $urandom}));
    endfunction

    function automatic t_in_item take_item();
        t_in_item it;
        it = random_item();
        it.req_type = 1'b1;
        return it;
    endfunction

    function automatic t_in_item bad_magic_item();
        t_in_item it;
        it = random_item();
        it.req_type = 1'b0;
        if (it.magic == MAGIC_OK) it.magic = ~MAGIC_OK;
        return it;
    endfunction

    function automatic t_in_item ignored_item();
        t_in_item it;
        it = random_item();
        it.req_type = 1'b0;
        it.magic = MAGIC_OK;
        if (it.sector_type == TYPE_VIDEO) it.sector_type = TYPE_VIDEO ^ 16'h0001;
        return it;
    endfunction

    // Sender: bursts of beats with idle gaps, occasionally long unbroken runs.
    task automatic send_beat(t_in_item it);
        in_data  <= it;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        board.note_beat(it);
        sent++;
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    task automatic send_frame();
        int         step;
        int         total;
        int         count;
        int         pick;
        logic [9:0] w;
        logic [9:0] h;
        step = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 300) : 1;
        if (next_frame + step > FRAME_CAP) step = (next_frame < FRAME_CAP) ? 1 : 0;
        next_frame += step;
        pick = $urandom_range(0, 99);
        if (pick < 2)      total = $urandom_range(17, 255);
        else if (pick < 5) total = 0;
        else               total = $urandom_range(1, 16);
        count = total;
        pick = $urandom_range(0, 99);
        if (pick < 15 && total > 1) count = $urandom_range(1, total - 1);
        else if (pick < 25)         count = total + $urandom_range(1, 3);
        if (count == 0) count = 1;
        w = 10'($urandom);
        h = 10'($urandom);
        for (int k = 0; k < count; k++) begin
            send_beat(sector_item(next_frame,
                ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(k), total, w, h));
            if ($urandom_range(0, 9) == 0) send_beat(take_item());
        end
    endtask

    task automatic directed_cases();
        t_in_item it;
        send_beat(take_item());                           // nothing ready yet
        send_beat(sector_item(0, 16'd0, 2, 10'd0, 10'd1023));
        send_beat(sector_item(0, 16'd16, 2, 10'd5, 10'd5)); // first index out of range
        send_beat(sector_item(0, 16'd15, 2, 10'd5, 10'd5)); // extra sector, top index
        send_beat(sector_item(1, 16'd0, 1, 10'd1023, 10'd1)); // frame 0 dropped
        send_beat(take_item());
        send_beat(ignored_item());
        send_beat(sector_item(2, 16'hFFFF, 0, 10'd17, 10'd16)); // frame 1 ready
        send_beat(take_item());
        send_beat(take_item());
        send_beat(sector_item(1, 16'd0, 1, 10'd0, 10'd0)); // older frame ends stream
        send_beat(take_item());
        send_beat(sector_item(2, 16'd3, 0, 10'd0, 10'd0));
        send_beat(sector_item(3, 16'd0, 255, 10'd1, 10'd0));
        it = sector_item(3, 16'd1, 255, 10'd0, 10'd0);
        it.magic = 16'hFFFF;
        send_beat(it);
        it = sector_item(3, 16'd2, 255, 10'd0, 10'd0);
        it.sector_type = TYPE_VIDEO ^ 16'h0001;
        send_beat(it);
        send_beat(take_item());
        send_beat(sector_item(4, 16'd0, 1, 10'd31, 10'd33));
        send_beat(sector_item(5, 16'd0, 1, 10'd32, 10'd48)); // ready again after end
        send_beat(take_item());
        send_beat(take_item());
        next_frame = 5;
    endtask

    initial begin
        int  pick;
        bit  paused;
        paused = 1'b0;
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        directed_cases();
        drain();
        while (sent < ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 75)      send_frame();
            else if (pick < 85) send_beat(take_item());
            else if (pick < 90) send_beat(bad_magic_item());
            else if (pick < 95) send_beat(ignored_item());
            else if (next_frame > 0)
                send_beat(sector_item($urandom_range(0, next_frame - 1), 16'($urandom),
                                      $urandom_range(0, 255), 10'($urandom), 10'($urandom)));
            if (!paused && sent > ITEMS / 2) begin
                paused = 1'b1;
                drain();
            end
        end
        // top frame number, then nothing newer can start
        send_beat(sector_item(65535, 16'd0, 1, 10'd1023, 10'd1023));
        send_beat(take_item());
        send_beat(sector_item(65535, 16'd1, 1, 10'd3, 10'd3));
        send_beat(sector_item(0, 16'd0, 1, 10'd0, 10'd0));
        send_beat(take_item());
        drain();
        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("video_sector_frame_assembler regression: pass");
        end else begin
            $display("video_sector_frame_assembler regression: fail");
        end
        $finish;
    end

    initial begin
        #(20 * 600000);
        $display("video_sector_frame_assembler regression: fail");
        $finish;
    end

endmodule

// ----- video_sector_frame_assembler.f -----
src/vsfa_pkg.sv
src/vsfa_front.sv
src/vsfa_queue.sv
src/vsfa_back.sv
src/video_sector_frame_assembler.sv
verif/video_sector_frame_assembler_tb.sv
